// File: rtl/agr_pkg.sv
// Shared types and constants for the audio gain ramp.
// Request structs for the sample and result channels, register indexes, reset values.
// No dependencies.
package agr_pkg;

  localparam int SAMPLE_W = 32;
  localparam int FRAMES_W = 13;
  localparam int GAIN_W   = 31;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Parameter defaults
  localparam int DEF_MAX_BLOCK_FRAMES  = 4096;
  localparam int DEF_MAX_CHANNEL_COUNT = 2;

  // Unity gain in Q31
  localparam logic [GAIN_W-1:0] FULL_SCALE = 31'h7FFF_FFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SAMPLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 8'd1;

  // Register reset values
  localparam logic [2:0] BPS_RESET = 3'd2;
  localparam logic [1:0] CHN_RESET = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_in;
    logic [FRAMES_W-1:0] block_frames;
    logic [GAIN_W-1:0]   target_gain;
    logic                new_session;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic                last_of_block;
  } out_t;

endpackage

// File: rtl/audio_gain_ramp.sv
// An accepted sample passes through S_PREP, S_MUL1, S_DIV, S_ADD, S_MUL2 and S_OUT in turn; a new
// request is taken only in S_IDLE, after the last result has been loaded into the output register.
// The ramp gain comes from a bit-serial restoring divider: one quotient bit a cycle.
// Pass-through blocks skip the arithmetic and go straight from S_IDLE to S_OUT.
// Reset (rst_n low, synchronous): gain full scale, block position zero, 2 bytes, 2 channels.
// Depends on agr_pkg.
module audio_gain_ramp #(
  parameter int MAX_BLOCK_FRAMES  = agr_pkg::DEF_MAX_BLOCK_FRAMES,
  parameter int MAX_CHANNEL_COUNT = agr_pkg::DEF_MAX_CHANNEL_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  agr_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output agr_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [agr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int GW     = agr_pkg::GAIN_W;
  localparam int FR_W   = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int CH_W   = (MAX_CHANNEL_COUNT > 1) ? $clog2(MAX_CHANNEL_COUNT) : 1;
  localparam int DIVD_W = GW + FR_W;
  localparam int DCNT_W = $clog2(DIVD_W);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_ADD  = 7'b0010000,
    S_MUL2 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t           st_r, st_nxt;
  logic [2:0]       bps_r, bps_nxt;
  logic [1:0]       chn_r, chn_nxt;
  logic [GW-1:0]    running_r, running_nxt;
  logic [GW-1:0]    start_r, start_nxt;
  logic [GW-1:0]    target_r, target_nxt;
  logic [FR_W-1:0]  frames_r, frames_nxt;
  logic [FR_W-1:0]  frame_pos_r, frame_pos_nxt;
  logic [CH_W-1:0]  ch_pos_r, ch_pos_nxt;
  logic             pass_r, pass_nxt;
  logic [31:0]      sample_r, sample_nxt;
  logic             dneg_r, dneg_nxt;
  logic [GW-1:0]    dmag_r, dmag_nxt;
  logic [DIVD_W-1:0] dq_r, dq_nxt;
  logic [FR_W-1:0]  rem_r, rem_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [GW-1:0]    gain_r, gain_nxt;
  logic [31:0]      scaled_r, scaled_nxt;
  logic             out_valid_r, out_valid_nxt;
  agr_pkg::out_t    out_data_r, out_data_nxt;

  logic [1:0]       nb_code;
  logic [1:0]       nch;
  logic             in_fire;
  logic             block_start;
  logic             out_load;
  logic [FR_W-1:0]  frames_clamped;
  logic [GW-1:0]    run_sel;
  logic [31:0]      delta;
  logic [31:0]      lj_sample;
  logic [31:0]      result;
  logic [FR_W:0]    trial;
  logic             trial_ge;
  logic [31:0]      gain_sum;
  logic [31:0]      ch_inc;
  logic [31:0]      fr_inc;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  assign in_ready  = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_fire     = in_valid && in_ready;
  assign block_start = (frame_pos_r == '0) && (ch_pos_r == '0);
  assign out_load    = (st_r == S_OUT) && (!out_valid_r || out_ready);

  // Map register values onto legal widths and channel counts
  always_comb begin
    if (bps_r == 3'd0) begin
      nb_code = 2'd0;
    end else if (bps_r > 3'd4) begin
      nb_code = 2'd3;
    end else begin
      nb_code = 2'(bps_r - 3'd1);
    end
    if (chn_r == 2'd0) begin
      nch = 2'd1;
    end else if (32'(chn_r) > 32'(MAX_CHANNEL_COUNT)) begin
      nch = 2'(MAX_CHANNEL_COUNT);
    end else begin
      nch = chn_r;
    end
  end

  // Clamp the block length and pick the starting gain
  always_comb begin
    if (in_data.block_frames == '0) begin
      frames_clamped = FR_W'(1);
    end else if (32'(in_data.block_frames) > 32'(MAX_BLOCK_FRAMES)) begin
      frames_clamped = FR_W'(MAX_BLOCK_FRAMES);
    end else begin
      frames_clamped = FR_W'(in_data.block_frames);
    end
    run_sel = in_data.new_session ? in_data.target_gain : running_r;
  end

  // Left-justify the sample to Q31 and scale the product back to its width
  always_comb begin
    case (nb_code)
      2'd0: begin
        lj_sample = {sample_r[7:0], 24'd0};
        result    = pass_r ? {24'd0, sample_r[7:0]} : {24'd0, scaled_r[31:24]};
      end
      2'd1: begin
        lj_sample = {sample_r[15:0], 16'd0};
        result    = pass_r ? {16'd0, sample_r[15:0]} : {16'd0, scaled_r[31:16]};
      end
      2'd2: begin
        lj_sample = {sample_r[23:0], 8'd0};
        result    = pass_r ? {8'd0, sample_r[23:0]} : {8'd0, scaled_r[31:8]};
      end
      default: begin
        lj_sample = sample_r;
        result    = pass_r ? sample_r : scaled_r;
      end
    endcase
  end

  // Shared multiplier: ramp numerator, then sample times gain
  always_comb begin
    if (st_r == S_MUL1) begin
      mul_a = $signed({2'b00, dmag_r});
      mul_b = $signed(33'(frame_pos_r) + 33'd1);
    end else begin
      mul_a = $signed({lj_sample[31], lj_sample});
      mul_b = $signed({2'b00, gain_r});
    end
    mul_p = mul_a * mul_b;
  end

  // Restoring divider step
  assign trial    = {rem_r, dq_r[DIVD_W-1]};
  assign trial_ge = (trial >= {1'b0, frames_r});

  assign delta    = {1'b0, target_r} - {1'b0, start_r};
  assign gain_sum = dneg_r ? ({1'b0, start_r} - {1'b0, dq_r[GW-1:0]})
                           : ({1'b0, start_r} + {1'b0, dq_r[GW-1:0]});
  assign ch_inc   = 32'(ch_pos_r) + 32'd1;
  assign fr_inc   = 32'(frame_pos_r) + 32'd1;

  // Sequencer and datapath next state
  always_comb begin
    st_nxt        = st_r;
    bps_nxt       = bps_r;
    chn_nxt       = chn_r;
    running_nxt   = running_r;
    start_nxt     = start_r;
    target_nxt    = target_r;
    frames_nxt    = frames_r;
    frame_pos_nxt = frame_pos_r;
    ch_pos_nxt    = ch_pos_r;
    pass_nxt      = pass_r;
    sample_nxt    = sample_r;
    dneg_nxt      = dneg_r;
    dmag_nxt      = dmag_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    gain_nxt      = gain_r;
    scaled_nxt    = scaled_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    // Register writes
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == agr_pkg::REG_BYTES_PER_SAMPLE) begin
        bps_nxt = cfg_data[2:0];
      end else if (cfg_index == agr_pkg::REG_CHANNEL_COUNT) begin
        chn_nxt = cfg_data[1:0];
      end
    end

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          sample_nxt = in_data.sample_in;
          if (block_start) begin
            frames_nxt  = frames_clamped;
            running_nxt = run_sel;
            start_nxt   = run_sel;
            target_nxt  = in_data.target_gain;
            pass_nxt    = (run_sel == agr_pkg::FULL_SCALE) &&
                          (in_data.target_gain == agr_pkg::FULL_SCALE);
          end
          st_nxt = pass_nxt ? S_OUT : S_PREP;
        end
      end
      S_PREP: begin
        // Split the ramp delta into sign and magnitude
        dneg_nxt = delta[31];
        dmag_nxt = delta[31] ? GW'(32'd0 - delta) : delta[GW-1:0];
        st_nxt   = S_MUL1;
      end
      S_MUL1: begin
        dq_nxt  = mul_p[DIVD_W-1:0];
        rem_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = S_DIV;
      end
      S_DIV: begin
        rem_nxt = trial_ge ? FR_W'(trial - {1'b0, frames_r}) : trial[FR_W-1:0];
        dq_nxt  = {dq_r[DIVD_W-2:0], trial_ge};
        cnt_nxt = cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIVD_W - 1)) begin
          st_nxt = S_ADD;
        end
      end
      S_ADD: begin
        gain_nxt = gain_sum[GW-1:0];
        st_nxt   = S_MUL2;
      end
      S_MUL2: begin
        // Floor shift right by 31
        scaled_nxt = mul_p[62:31];
        st_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.sample_out    = result;
          out_data_nxt.last_of_block = 1'b0;
          // Advance channel and frame position
          if (ch_inc >= 32'(nch)) begin
            ch_pos_nxt = '0;
            if (fr_inc >= 32'(frames_r)) begin
              frame_pos_nxt              = '0;
              running_nxt                = target_r;
              out_data_nxt.last_of_block = 1'b1;
            end else begin
              frame_pos_nxt = FR_W'(fr_inc);
            end
          end else begin
            ch_pos_nxt = CH_W'(ch_inc);
          end
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      bps_r       <= agr_pkg::BPS_RESET;
      chn_r       <= agr_pkg::CHN_RESET;
      running_r   <= agr_pkg::FULL_SCALE;
      start_r     <= '0;
      target_r    <= '0;
      frames_r    <= '0;
      frame_pos_r <= '0;
      ch_pos_r    <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      bps_r       <= bps_nxt;
      chn_r       <= chn_nxt;
      running_r   <= running_nxt;
      start_r     <= start_nxt;
      target_r    <= target_nxt;
      frames_r    <= frames_nxt;
      frame_pos_r <= frame_pos_nxt;
      ch_pos_r    <= ch_pos_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    dneg_r     <= dneg_nxt;
    dmag_r     <= dmag_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    gain_r     <= gain_nxt;
    scaled_r   <= scaled_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // A result marked last leaves the block position at the start of a block
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_data_r.last_of_block == ((frame_pos_r == '0) && (ch_pos_r == '0))))
    else $error("last_of_block disagrees with block position");

  // Channel position stays below the channel limit
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ch_pos_r) < 32'(MAX_CHANNEL_COUNT))
    else $error("channel position out of range");

  // Frame position stays inside the latched block
  a_fr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_pos_r == '0) || (frame_pos_r < frames_r))
    else $error("frame position past block length");

  // Divider remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (rem_r < frames_r))
    else $error("divider remainder not reduced");
`endif

endmodule
